[design/acf_pkg.sv]
// Shared types, constants and helpers for the accelerometer calibration and EMA filter.
package acf_pkg;

  localparam int unsigned EXTRA_FRAC_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_BIAS    = 3'd0,
    REG_Y_BIAS    = 3'd1,
    REG_Z_BIAS    = 3'd2,
    REG_X_GAIN    = 3'd3,
    REG_Y_GAIN    = 3'd4,
    REG_Z_GAIN    = 3'd5,
    REG_THRESHOLD = 3'd6,
    REG_ALPHA     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] x_bias;
    logic [11:0] y_bias;
    logic [11:0] z_bias;
    logic [15:0] x_gain;
    logic [15:0] y_gain;
    logic [15:0] z_gain;
    logic [14:0] level_threshold;
    logic [15:0] smoothing_alpha;
  } cfg_t;

  localparam logic [11:0] X_BIAS_RST    = 12'd298;
  localparam logic [11:0] Y_BIAS_RST    = 12'hF88;  // -120
  localparam logic [11:0] Z_BIAS_RST    = 12'd379;
  localparam logic [15:0] X_GAIN_RST    = 16'd32708;
  localparam logic [15:0] Y_GAIN_RST    = 16'd32696;
  localparam logic [15:0] Z_GAIN_RST    = 16'd32546;
  localparam logic [14:0] THRESHOLD_RST = 15'd5120;
  localparam logic [15:0] ALPHA_RST     = 16'd25892;

  // Fixed offsets for the low-level path, Q5.10.
  localparam logic [7:0] OFFSET_XZ = 8'd154;
  localparam logic [7:0] OFFSET_Y  = 8'd10;

  // Count to Q5.10 conversion: round(raw * 981 / 1600).
  // A bias of 1600*20100 (plus the rounding half) keeps the dividend positive;
  // the division by 1600 is a shift by 6 and a divide by 25.
  localparam logic signed [26:0] CONV_MUL   = 27'sd981;
  localparam logic signed [26:0] CONV_BIAS  = 27'sd32160800;
  localparam logic [16:0]        CONV_SHIFT = 17'd20100;
  localparam logic [15:0]        RECIP_25   = 16'd41943;  // floor(2^20 / 25)
  localparam logic [20:0]        DIV_25     = 21'd25;

  // Per-lane stage strobes from the sequencer.
  typedef struct packed {
    logic load;
    logic conv;
    logic div;
    logic quot;
    logic gain;
    logic cal;
    logic diff;
    logic mul;
    logic upd;
  } lane_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[design/acf_cfg_regs.sv]
// Configuration register file: bias, gain, threshold and smoothing weight.
module acf_cfg_regs
  import acf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_X_BIAS:    cfg_d.x_bias          = cfg_wdata_i[11:0];
        REG_Y_BIAS:    cfg_d.y_bias          = cfg_wdata_i[11:0];
        REG_Z_BIAS:    cfg_d.z_bias          = cfg_wdata_i[11:0];
        REG_X_GAIN:    cfg_d.x_gain          = cfg_wdata_i;
        REG_Y_GAIN:    cfg_d.y_gain          = cfg_wdata_i;
        REG_Z_GAIN:    cfg_d.z_gain          = cfg_wdata_i;
        REG_THRESHOLD: cfg_d.level_threshold = cfg_wdata_i[14:0];
        REG_ALPHA:     cfg_d.smoothing_alpha = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_bias          <= X_BIAS_RST;
      cfg_q.y_bias          <= Y_BIAS_RST;
      cfg_q.z_bias          <= Z_BIAS_RST;
      cfg_q.x_gain          <= X_GAIN_RST;
      cfg_q.y_gain          <= Y_GAIN_RST;
      cfg_q.z_gain          <= Z_GAIN_RST;
      cfg_q.level_threshold <= THRESHOLD_RST;
      cfg_q.smoothing_alpha <= ALPHA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/acf_lane.sv]
// One axis: count conversion, threshold select, gain/offset calibration and EMA update.
module acf_lane
  import acf_pkg::*;
#(
  parameter int unsigned EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctrl_t         ctrl_i,
  input  logic signed [15:0] raw_i,
  input  logic        [11:0] bias_i,
  input  logic        [15:0] gain_i,
  input  logic        [7:0]  offset_i,
  input  logic        [14:0] thr_i,
  input  logic        [15:0] alpha_i,
  output logic signed [15:0] cal_o,
  output logic signed [15:0] smooth_o
);

  localparam int unsigned AW = 16 + EXTRA_FRAC_BITS;  // average width
  localparam int unsigned DW = AW + 1;                // difference width
  localparam int unsigned PW = EXTRA_FRAC_BITS + 18;  // high partial product
  localparam int unsigned SW = PW + 1;                // update sum width

  logic signed [15:0]   raw_q;
  logic        [19:0]   x_q;
  logic        [15:0]   q0_q;
  logic signed [15:0]   conv_q;
  logic signed [33:0]   prod_g_q;
  logic                 sel_q;
  logic signed [16:0]   offv_q;
  logic signed [15:0]   cal_q;
  logic signed [DW-1:0] d_q;
  logic signed [PW-1:0] phi_q;
  logic        [31:0]   plo_q;
  logic signed [AW-1:0] avg_q, avg_d;

  logic signed [26:0]   conv_num;
  logic        [35:0]   recip_prod;
  logic        [20:0]   rem;
  logic        [16:0]   quot;
  logic signed [16:0]   conv_sum;
  logic signed [16:0]   cal_diff;
  logic signed [33:0]   gain_rnd;
  logic signed [15:0]   cal_d;
  logic signed [AW-1:0] target;
  logic signed [SW-1:0] avg_sum;
  logic        [32:0]   lo_rnd;

  // Stage: conversion numerator, kept positive.
  assign conv_num = 27'(raw_q) * CONV_MUL + CONV_BIAS;

  // Stage: divide by 25 by reciprocal, then correct by one.
  assign recip_prod = 36'(x_q) * 36'(RECIP_25);
  assign rem        = 21'(x_q) - 21'(q0_q) * DIV_25;
  assign quot       = 17'(q0_q) + 17'(rem >= DIV_25);
  assign conv_sum   = $signed(quot - CONV_SHIFT);

  // Stage: calibration select.
  assign cal_diff = 17'(conv_q) - 17'($signed(bias_i));
  assign gain_rnd = (prod_g_q + 34'sd16384) >>> 15;
  assign cal_d    = sel_q ? sat16(20'($signed(gain_rnd[18:0]))) : sat16(20'(offv_q));

  // Stage: filter difference and update.
  assign target  = AW'(cal_q) <<< EXTRA_FRAC_BITS;
  assign lo_rnd  = 33'(plo_q) + 33'd32768;
  assign avg_sum = SW'(avg_q) + SW'(phi_q) + SW'($signed({1'b0, lo_rnd[32:16]}));
  assign avg_d   = avg_sum[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      raw_q <= raw_i;
    end
    if (ctrl_i.conv) begin
      x_q <= conv_num[25:6];
    end
    if (ctrl_i.div) begin
      q0_q <= recip_prod[35:20];
    end
    if (ctrl_i.quot) begin
      conv_q <= conv_sum[15:0];
    end
    if (ctrl_i.gain) begin
      prod_g_q <= 34'(cal_diff) * 34'($signed({1'b0, gain_i}));
      sel_q    <= conv_q > $signed({1'b0, thr_i});
      offv_q   <= 17'(conv_q) - $signed({9'd0, offset_i});
    end
    if (ctrl_i.cal) begin
      cal_q <= cal_d;
    end
    if (ctrl_i.diff) begin
      d_q <= DW'(target) - DW'(avg_q);
    end
    if (ctrl_i.mul) begin
      phi_q <= PW'($signed(d_q[DW-1:16])) * PW'($signed({1'b0, alpha_i}));
      plo_q <= d_q[15:0] * alpha_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (ctrl_i.upd) begin
      avg_q <= avg_d;
    end
  end

  // Round the average back to Q5.10.
  generate
    if (EXTRA_FRAC_BITS == 0) begin : g_no_frac
      assign smooth_o = avg_q[15:0];
    end else begin : g_frac
      localparam logic signed [AW:0] HALF = (AW + 1)'(1) << (EXTRA_FRAC_BITS - 1);
      logic signed [AW:0] rsum;
      logic signed [AW:0] rsh;
      assign rsum     = (AW + 1)'(avg_q) + HALF;
      assign rsh      = rsum >>> EXTRA_FRAC_BITS;
      assign smooth_o = sat16(20'($signed(rsh[16:0])));
    end
  endgenerate

  assign cal_o = cal_q;

endmodule

[design/accel_calibrate_ema_filter_core.sv]
// Top level: three axis lanes, stage sequencer, config registers and result register.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   raw_x_i, raw_y_i, raw_z_i
//   out      source     out_valid_o / out_stall_i cal_{x,y,z}_o, smooth_{x,y,z}_o
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A transaction steps from input accept through the conv, div, quot, gain, cal,
// diff, mul, upd and out states, following the per-axis chain of conversion,
// divide-by-25 correction, gain multiply, rounding, and the two-step alpha multiply
// that feeds the average. Inputs wait until the out state loads the result register.
// Reset clears the sequencer, the result valid and the averages, and loads the
// register defaults. A stalled result holds in the output register; the last
// stage waits until that register is free.
module accel_calibrate_ema_filter_core
  import acf_pkg::*;
#(
  parameter int unsigned EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input transaction
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [15:0]    raw_x_i,
  input  logic signed [15:0]    raw_y_i,
  input  logic signed [15:0]    raw_z_i,
  // result transaction
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    cal_x_o,
  output logic signed [15:0]    cal_y_o,
  output logic signed [15:0]    cal_z_o,
  output logic signed [15:0]    smooth_x_o,
  output logic signed [15:0]    smooth_y_o,
  output logic signed [15:0]    smooth_z_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_CONV = 10'b00_0000_0010,
    ST_DIV  = 10'b00_0000_0100,
    ST_QUOT = 10'b00_0000_1000,
    ST_GAIN = 10'b00_0001_0000,
    ST_CAL  = 10'b00_0010_0000,
    ST_DIFF = 10'b00_0100_0000,
    ST_MUL  = 10'b00_1000_0000,
    ST_UPD  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

  state_e     state_q, state_d;
  lane_ctrl_t ctrl;
  cfg_t       cfg;
  logic       in_accept;
  logic       out_load;
  logic       out_valid_q, out_valid_d;

  logic signed [15:0] cal_x, cal_y, cal_z;
  logic signed [15:0] smooth_x, smooth_y, smooth_z;
  logic signed [15:0] cal_x_q, cal_y_q, cal_z_q;
  logic signed [15:0] smooth_x_q, smooth_y_q, smooth_z_q;

  // Take a new sample only while no sample is in flight.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);

  // Move the finished sample into the result register when it is empty or draining.
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_CONV;
      ST_CONV: state_d = ST_DIV;
      ST_DIV:  state_d = ST_QUOT;
      ST_QUOT: state_d = ST_GAIN;
      ST_GAIN: state_d = ST_CAL;
      ST_CAL:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.load = in_accept;
    ctrl.conv = (state_q == ST_CONV);
    ctrl.div  = (state_q == ST_DIV);
    ctrl.quot = (state_q == ST_QUOT);
    ctrl.gain = (state_q == ST_GAIN);
    ctrl.cal  = (state_q == ST_CAL);
    ctrl.diff = (state_q == ST_DIFF);
    ctrl.mul  = (state_q == ST_MUL);
    ctrl.upd  = (state_q == ST_UPD);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Merge the three lanes into one result.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cal_x_q    <= cal_x;
      cal_y_q    <= cal_y;
      cal_z_q    <= cal_z;
      smooth_x_q <= smooth_x;
      smooth_y_q <= smooth_y;
      smooth_z_q <= smooth_z;
    end
  end

  acf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  acf_lane #(.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .raw_i    (raw_x_i),
    .bias_i   (cfg.x_bias),
    .gain_i   (cfg.x_gain),
    .offset_i (OFFSET_XZ),
    .thr_i    (cfg.level_threshold),
    .alpha_i  (cfg.smoothing_alpha),
    .cal_o    (cal_x),
    .smooth_o (smooth_x)
  );

  acf_lane #(.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .raw_i    (raw_y_i),
    .bias_i   (cfg.y_bias),
    .gain_i   (cfg.y_gain),
    .offset_i (OFFSET_Y),
    .thr_i    (cfg.level_threshold),
    .alpha_i  (cfg.smoothing_alpha),
    .cal_o    (cal_y),
    .smooth_o (smooth_y)
  );

  acf_lane #(.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .raw_i    (raw_z_i),
    .bias_i   (cfg.z_bias),
    .gain_i   (cfg.z_gain),
    .offset_i (OFFSET_XZ),
    .thr_i    (cfg.level_threshold),
    .alpha_i  (cfg.smoothing_alpha),
    .cal_o    (cal_z),
    .smooth_o (smooth_z)
  );

  assign out_valid_o = out_valid_q;
  assign cal_x_o     = cal_x_q;
  assign cal_y_o     = cal_y_q;
  assign cal_z_o     = cal_z_q;
  assign smooth_x_o  = smooth_x_q;
  assign smooth_y_o  = smooth_y_q;
  assign smooth_z_o  = smooth_z_q;

endmodule

[design/acf_checker.sv]
// Port-level checks for the accelerometer calibration core, bound to the top level.
module acf_checker
  import acf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic signed [15:0]    cal_x_o,
  input logic signed [15:0]    smooth_x_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cal_x_o) && $stable(smooth_x_o))
    else $error("stalled result changed");

  // An accepted sample keeps the input side busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after accept");

  // A new result only appears at the end of a sample in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without sample in flight");

endmodule

bind accel_calibrate_ema_filter_core acf_checker u_acf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cal_x_o     (cal_x_o),
  .smooth_x_o  (smooth_x_o)
);
